### hw/rtl/dq_pkg.sv
// dq_pkg: shared types and constants for the double-ended queue
// used by the channel interfaces, the storage cell and the top level

package dq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed payload field widths
    localparam int REQ_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int MASK_W   = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_REAR  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_REAR   = 3'd3,
        REQ_SEARCH     = 3'd4,
        REQ_CLEAR      = 3'd5
    } t_req_type;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic push_rear;
        logic push_front;
        logic pop_front;
        logic pop_rear;
        logic clear;
    } t_cell_op;

endpackage

### hw/rtl/dq_if.sv
// dq_if: request and response channel interfaces for the double-ended queue
// depends on dq_pkg for field widths

interface dq_req_if;
    logic                           valid;
    logic                           ready;
    logic [dq_pkg::REQ_W-1:0]       req_type;
    logic signed [dq_pkg::VALUE_W-1:0] value;

    modport source (output valid, req_type, value, input ready);
    modport sink   (input valid, req_type, value, output ready);
endinterface

interface dq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [dq_pkg::STATUS_W-1:0]       status;
    logic signed [dq_pkg::VALUE_W-1:0] front_value;
    logic signed [dq_pkg::VALUE_W-1:0] rear_value;
    logic [dq_pkg::OCC_W-1:0]          occupancy;
    logic                              is_empty;
    logic [dq_pkg::MASK_W-1:0]         match_mask;
    logic                              found;

    modport source (output valid, status, front_value, rear_value, occupancy,
                    is_empty, match_mask, found, input ready);
    modport sink   (input valid, status, front_value, rear_value, occupancy,
                    is_empty, match_mask, found, output ready);
endinterface

### hw/rtl/dq_cell.sv
// dq_cell: one queue position, holds a word and its occupied bit
// depends on dq_pkg for the cell command struct

module dq_cell #(
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dq_pkg::t_cell_op      i_op,
    input  logic [DATA_WIDTH-1:0] i_key,
    input  logic [DATA_WIDTH-1:0] i_left_data,
    input  logic                  i_left_vld,
    input  logic [DATA_WIDTH-1:0] i_right_data,
    input  logic                  i_right_vld,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_vld,
    output logic                  o_match,
    output logic                  o_last
);

    logic [DATA_WIDTH-1:0] r_data, n_data;
    logic                  r_vld, n_vld;

    always_comb begin
        n_data = r_data;
        n_vld  = r_vld;
        if (i_op.clear) begin
            n_vld = 1'b0;
        end else if (i_op.push_front) begin
            n_data = i_left_data;
            n_vld  = i_left_vld;
        end else if (i_op.push_rear) begin
            // first free position takes the new word
            if (i_left_vld && !r_vld) begin
                n_data = i_key;
                n_vld  = 1'b1;
            end
        end else if (i_op.pop_front) begin
            n_data = i_right_data;
            n_vld  = i_right_vld;
        end else if (i_op.pop_rear) begin
            n_vld = i_right_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_data  = r_data;
    assign o_vld   = r_vld;
    assign o_match = r_vld && (r_data == i_key);
    assign o_last  = r_vld && !i_right_vld;

endmodule

### hw/rtl/double_ended_queue.sv
// double_ended_queue: bounded deque built as a shifting chain of cells
// a request is registered in stage 1 (cells and side results), then in the output register until its result is taken
// throughput: one request per cycle while the response is not held back; the whole chain shifts at once
// the response side is double registered, so a request is taken while a result waits
// reset: occupancy and all cell occupied bits clear at once; stored data is not cleared
// depends on dq_pkg, dq_if and dq_cell

module double_ended_queue #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    dq_req_if.sink   i_req,
    dq_rsp_if.source o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    // cell chain taps
    logic [DATA_WIDTH-1:0] w_data  [DEPTH];
    logic                  w_vld   [DEPTH];
    logic                  w_match [DEPTH];
    logic                  w_last  [DEPTH];

    logic [DATA_WIDTH-1:0] w_key;
    logic [63:0]           w_value_ext;
    dq_pkg::t_cell_op      w_op;

    // occupancy counter
    logic [CW-1:0] r_count, n_count;
    logic          w_full, w_empty;

    // stage 1: request decoded, cells updated, side results held
    logic                         r_p_valid;
    logic [dq_pkg::STATUS_W-1:0]  r_p_status;
    logic [dq_pkg::MASK_W-1:0]    r_p_mask;
    logic                         r_p_found;
    dq_pkg::t_status              w_status;
    logic [dq_pkg::MASK_W-1:0]    w_mask;
    logic                         w_found;
    logic                         w_search;

    // stage 2: output register
    logic                              r_o_valid;
    logic [dq_pkg::STATUS_W-1:0]       r_o_status;
    logic signed [dq_pkg::VALUE_W-1:0] r_o_front;
    logic signed [dq_pkg::VALUE_W-1:0] r_o_rear;
    logic [dq_pkg::OCC_W-1:0]          r_o_occ;
    logic                              r_o_empty;
    logic [dq_pkg::MASK_W-1:0]         r_o_mask;
    logic                              r_o_found;

    logic                  w_accept, w_load_out;
    logic [DATA_WIDTH-1:0] w_rear_data;
    logic [63:0]           w_front_ext, w_rear_ext, w_count_ext;

    // handshake: stage 1 frees up when its result moves into the output register
    assign w_load_out  = r_p_valid && (!r_o_valid || o_rsp.ready);
    assign i_req.ready = !r_p_valid || w_load_out;
    assign w_accept    = i_req.valid && i_req.ready;

    // key and push word at DATA_WIDTH bits
    assign w_value_ext = 64'(i_req.value);
    assign w_key       = w_value_ext[DATA_WIDTH-1:0];

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    // request decode: illegal pushes and pops do nothing to the chain
    always_comb begin
        w_op     = '0;
        w_status = dq_pkg::ST_OK;
        w_search = 1'b0;
        n_count  = r_count;
        if (w_accept) begin
            unique case (dq_pkg::t_req_type'(i_req.req_type))
                dq_pkg::REQ_PUSH_REAR: begin
                    if (w_full) begin
                        w_status = dq_pkg::ST_OVERFLOW;
                    end else begin
                        w_op.push_rear = 1'b1;
                        n_count        = r_count + 1'b1;
                    end
                end
                dq_pkg::REQ_PUSH_FRONT: begin
                    if (w_full) begin
                        w_status = dq_pkg::ST_OVERFLOW;
                    end else begin
                        w_op.push_front = 1'b1;
                        n_count         = r_count + 1'b1;
                    end
                end
                dq_pkg::REQ_POP_FRONT: begin
                    if (w_empty) begin
                        w_status = dq_pkg::ST_UNDERFLOW;
                    end else begin
                        w_op.pop_front = 1'b1;
                        n_count        = r_count - 1'b1;
                    end
                end
                dq_pkg::REQ_POP_REAR: begin
                    if (w_empty) begin
                        w_status = dq_pkg::ST_UNDERFLOW;
                    end else begin
                        w_op.pop_rear = 1'b1;
                        n_count       = r_count - 1'b1;
                    end
                end
                dq_pkg::REQ_SEARCH: begin
                    w_search = 1'b1;
                end
                dq_pkg::REQ_CLEAR: begin
                    w_op.clear = 1'b1;
                    n_count    = '0;
                end
                default: begin
                    // unused codes leave everything unchanged
                end
            endcase
        end
    end

    // the chain: position 0 is the front; each inner cell sees its two neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_l_data, w_r_data;
        logic                  w_l_vld, w_r_vld;

        if (g == 0) begin : g_first
            // push front enters here; push rear may land here on an empty queue
            assign w_l_data = w_key;
            assign w_l_vld  = 1'b1;
        end else begin : g_inner_l
            assign w_l_data = w_data[g-1];
            assign w_l_vld  = w_vld[g-1];
        end

        if (g == DEPTH - 1) begin : g_end
            assign w_r_data = w_data[g];
            assign w_r_vld  = 1'b0;
        end else begin : g_inner_r
            assign w_r_data = w_data[g+1];
            assign w_r_vld  = w_vld[g+1];
        end

        dq_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_op        (w_op),
            .i_key       (w_key),
            .i_left_data (w_l_data),
            .i_left_vld  (w_l_vld),
            .i_right_data(w_r_data),
            .i_right_vld (w_r_vld),
            .o_data      (w_data[g]),
            .o_vld       (w_vld[g]),
            .o_match     (w_match[g]),
            .o_last      (w_last[g])
        );
    end

    // search: per-cell compare, mask covers the first sixteen positions only
    always_comb begin
        w_mask  = '0;
        w_found = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            w_found = w_found | (w_search & w_match[i]);
        end
        for (int i = 0; i < dq_pkg::MASK_W; i++) begin
            if (i < DEPTH) begin
                w_mask[i] = w_search & w_match[i];
            end
        end
    end

    // rear word: the occupied cell whose right neighbor is empty
    always_comb begin
        w_rear_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rear_data = w_rear_data | (w_data[i] & {DATA_WIDTH{w_last[i]}});
        end
    end

    // front and rear sign-extended to the output width
    assign w_front_ext = 64'(signed'(w_data[0]));
    assign w_rear_ext  = 64'(signed'(w_rear_data));
    assign w_count_ext = 64'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_p_valid <= 1'b1;
            end else if (w_load_out) begin
                r_p_valid <= 1'b0;
            end
            if (w_load_out) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p_status <= w_status;
            r_p_mask   <= w_mask;
            r_p_found  <= w_found;
        end
        // the chain and counter here reflect exactly the item in stage 1
        if (w_load_out) begin
            r_o_status <= r_p_status;
            r_o_mask   <= r_p_mask;
            r_o_found  <= r_p_found;
            r_o_occ    <= w_count_ext[dq_pkg::OCC_W-1:0];
            r_o_empty  <= w_empty;
            if (w_empty) begin
                r_o_front <= '1;
                r_o_rear  <= '1;
            end else begin
                r_o_front <= w_front_ext[dq_pkg::VALUE_W-1:0];
                r_o_rear  <= w_rear_ext[dq_pkg::VALUE_W-1:0];
            end
        end
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.front_value = r_o_front;
    assign o_rsp.rear_value  = r_o_rear;
    assign o_rsp.occupancy   = r_o_occ;
    assign o_rsp.is_empty    = r_o_empty;
    assign o_rsp.match_mask  = r_o_mask;
    assign o_rsp.found       = r_o_found;

endmodule
